// ===== sv/sti_pkg.sv =====
// Shared codes and types for the sorted table block.
package sti_pkg;

  localparam int unsigned ValW = 32;

  // Operation codes carried on in_func.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // One result item offered by the sequencer to the output register.
  typedef struct packed {
    logic                   valid;
    logic [1:0]             status;
    logic signed [ValW-1:0] element;
    logic                   last;
  } res_t;

endpackage

// ===== sv/sorted_table_insert_delete.sv =====
// Sorted table: keeps up to DEPTH signed 32-bit values in ascending order. An item on the
// input channel is an insert, a delete or a dump (in_func); every item but the undefined
// code 3 yields results on the output channel, and out_last marks its final one. Insert
// answers once with ok or full, delete once with ok, not found or empty, dump with one
// result per stored value in ascending order (or one empty result). The block takes one
// item at a time: in_ready is low from acceptance until the item's last result has moved
// into the output register. The store is a single memory with one write and one registered
// read port, walked one entry a cycle by a sequencer with one compare unit (a dump waits
// while its result is not taken), so the read port sets the pace. Insert scans from the top
// down, moving each larger-or-equal entry up by one. Delete scans from the bottom to the
// match and shifts the rest down. Full, empty and ignored items need no scan of the store.
// The output register frees the sequencer while a result waits to be taken, so a new item
// can be accepted then. No clearing pass after reset.
module sorted_table_insert_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic signed [sti_pkg::ValW-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic signed [sti_pkg::ValW-1:0] out_element,
  output logic                            out_last
);

  sti_pkg::res_t res;
  logic          res_ready;

  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic signed [sti_pkg::ValW-1:0] out_element_r;
  logic                            out_last_r;

  // Sequencer with the value store and the shared compare unit.
  sti_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_value  (in_value),
    .res       (res),
    .res_ready (res_ready)
  );

  // Load the output register when it is empty or its item leaves this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  // Hold the payload while a result waits.
  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status_r  <= res.status;
      out_element_r <= res.element;
      out_last_r    <= res.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

// ===== sv/sti_ram.sv =====
// Value store: one write port and one enabled read port with registered read data.
module sti_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [sti_pkg::ValW-1:0] wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic signed [sti_pkg::ValW-1:0] rdata
);

  logic signed [sti_pkg::ValW-1:0] mem_r [DEPTH];
  logic signed [sti_pkg::ValW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Hold the read data until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sti_seq.sv =====
// Sequencer: walks the store one entry a cycle through a shared compare unit, a dump only while results are taken.
module sti_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic signed [sti_pkg::ValW-1:0] in_value,
  output sti_pkg::res_t                   res,
  input  logic                            res_ready
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DUMP  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [AW-1:0]                   idx_r, idx_nxt;
  logic signed [sti_pkg::ValW-1:0] val_r, val_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [1:0]                      status_r, status_nxt;

  logic                            we, re;
  logic [AW-1:0]                   waddr, raddr;
  logic signed [sti_pkg::ValW-1:0] wdata, rdata;

  logic          cmp_ge, cmp_eq;
  logic [AW-1:0] last_idx, idx_inc, idx_dec;

  sti_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared compare unit: stored entry against the operand.
  assign cmp_ge = (rdata >= val_r);
  assign cmp_eq = (rdata == val_r);

  assign last_idx = AW'(count_r - CW'(1));
  assign idx_inc  = idx_r + AW'(1);
  assign idx_dec  = idx_r - AW'(1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = idx_r;
    res.valid   = 1'b0;
    res.status  = sti_pkg::ST_OK;
    res.element = '0;
    res.last    = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          case (in_func)
            sti_pkg::FUNC_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = sti_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else if (count_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                re        = 1'b1;
                raddr     = last_idx;
                idx_nxt   = last_idx;
                state_nxt = S_INS;
              end
            end
            sti_pkg::FUNC_DELETE, sti_pkg::FUNC_DUMP: begin
              if (count_r == '0) begin
                status_nxt = sti_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                re        = 1'b1;
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = (in_func == sti_pkg::FUNC_DUMP) ? S_DUMP : S_FIND;
              end
            end
            default: begin
              // Drop undefined operations.
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = idx_inc;
        if (cmp_ge) begin
          wdata = rdata;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            re      = 1'b1;
            raddr   = idx_dec;
            idx_nxt = idx_dec;
          end
        end else begin
          wdata      = val_r;
          count_nxt  = count_r + CW'(1);
          status_nxt = sti_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = idx_r;
        wdata      = val_r;
        count_nxt  = count_r + CW'(1);
        status_nxt = sti_pkg::ST_OK;
        state_nxt  = S_RESP;
      end
      S_FIND: begin
        if (idx_r == last_idx) begin
          if (cmp_eq) begin
            count_nxt  = count_r - CW'(1);
            status_nxt = sti_pkg::ST_OK;
          end else begin
            status_nxt = sti_pkg::ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end else begin
          re      = 1'b1;
          raddr   = idx_inc;
          idx_nxt = idx_inc;
          if (cmp_eq) begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_dec;
        wdata = rdata;
        if (idx_r == last_idx) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = sti_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          re      = 1'b1;
          raddr   = idx_inc;
          idx_nxt = idx_inc;
        end
      end
      S_DUMP: begin
        res.valid   = 1'b1;
        res.element = rdata;
        res.last    = (idx_r == last_idx);
        if (res_ready) begin
          if (idx_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = idx_inc;
            idx_nxt = idx_inc;
          end
        end
      end
      S_RESP: begin
        res.valid  = 1'b1;
        res.status = status_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted table block: directed and random items.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  // Operation code 3 is undefined; the block must swallow it silently.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RandomItems = 195;
  localparam int unsigned ReceiverHold = 300;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [1:0]                      status;
    logic signed [sti_pkg::ValW-1:0] element;
    logic                            last;
  } table_result_t;

  typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} mood_t;

  // Tracks the table contents and the results still owed by the block.
  class table_tracker_t;
    logic signed [sti_pkg::ValW-1:0] entries [Depth];
    int unsigned                     fill;
    table_result_t                   pending_results [$];
    int unsigned                     mismatches;
    int unsigned                     checked;
    int unsigned                     status_seen [4];

    function void note_item(logic [1:0] func, logic signed [sti_pkg::ValW-1:0] value);
      int unsigned   pos;
      table_result_t res;
      res.status  = sti_pkg::ST_OK;
      res.element = '0;
      res.last    = 1'b1;
      pos = 0;
      case (func)
        sti_pkg::FUNC_INSERT: begin
          if (fill >= Depth) begin
            res.status = sti_pkg::ST_FULL;
          end else begin
            while (pos < fill && entries[pos] < value) pos++;
            for (int i = int'(fill); i > int'(pos); i--) entries[i] = entries[i-1];
            entries[pos] = value;
            fill++;
          end
          pending_results.push_back(res);
        end
        sti_pkg::FUNC_DELETE: begin
          if (fill == 0) begin
            res.status = sti_pkg::ST_EMPTY;
          end else begin
            while (pos < fill && entries[pos] != value) pos++;
            if (pos >= fill) begin
              res.status = sti_pkg::ST_NOTFOUND;
            end else begin
              for (int unsigned i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
              fill--;
            end
          end
          pending_results.push_back(res);
        end
        sti_pkg::FUNC_DUMP: begin
          if (fill == 0) begin
            res.status = sti_pkg::ST_EMPTY;
            pending_results.push_back(res);
          end else begin
            for (int unsigned i = 0; i < fill; i++) begin
              res.element = entries[i];
              res.last    = (i + 1 == fill);
              pending_results.push_back(res);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, table_result_t want, table_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch (%s): expected status %0d element %0d last %0d",
                 $time, what, want.status, want.element, want.last);
        $display("    got status %0d element %0d last %0d",
                 got.status, got.element, got.last);
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      checked++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        want = '0;
        flag("nothing outstanding", want, got);
      end else begin
        want = pending_results.pop_front();
        if (want.status != got.status || want.element != got.element ||
            want.last != got.last)
          flag("field", want, got);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [1:0]                      in_func;
  logic signed [sti_pkg::ValW-1:0] in_value;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      out_status;
  logic signed [sti_pkg::ValW-1:0] out_element;
  logic                            out_last;

  table_tracker_t tracker = new();

  // Shared pacing flags, written only by the stimulus process.
  bit steady;     // no idling on either side while set
  bit hold_req;   // ask the receiver for its one long hold-off

  int unsigned cycle_count;
  int unsigned n_insert, n_delete, n_dump, n_ignored;

  sorted_table_insert_delete #(.DEPTH(Depth)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_element(out_element),
    .out_last   (out_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: end the run if the block hangs or stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sorted_table_insert_delete regression: fail");
      $finish;
    end
  end

  // Present one item at a falling edge, hold it until taken, then log it.
  task automatic send_item(logic [1:0] func, logic signed [sti_pkg::ValW-1:0] value);
    int unsigned gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 16) begin
      // Drop valid for a short random gap before the next item.
      in_valid = 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func  = func;
    in_value = value;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(func, value);
    case (func)
      sti_pkg::FUNC_INSERT: n_insert++;
      sti_pkg::FUNC_DELETE: n_delete++;
      sti_pkg::FUNC_DUMP:   n_dump++;
      default:              n_ignored++;
    endcase
  endtask

  // Pick a value: stored values for hits, a narrow band for duplicates,
  // the extremes, or the full 32-bit range.
  function automatic logic signed [sti_pkg::ValW-1:0] pick_value(bit want_hit);
    int unsigned roll;
    roll = $urandom_range(99);
    if (tracker.fill > 0 && ((want_hit && roll < 75) || (!want_hit && roll < 15)))
      return tracker.entries[$urandom_range(tracker.fill - 1)];
    roll = $urandom_range(99);
    if (roll < 45) return $signed($urandom_range(20)) - 10;
    if (roll < 55) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh8000_0001;
        default: return 32'sh7fff_fffe;
      endcase
    end
    return $urandom;
  endfunction

  // Directed part: every operation, the extremes and each corner case.
  task automatic run_directed();
    send_item(sti_pkg::FUNC_DUMP,   0);              // dump of an empty table
    send_item(sti_pkg::FUNC_DELETE, 5);              // delete from an empty table
    send_item(FUNC_UNUSED,          32'shffff_ffff); // undefined code, no result
    send_item(sti_pkg::FUNC_INSERT, 32'sh7fff_ffff);
    send_item(sti_pkg::FUNC_INSERT, 32'sh8000_0000);
    send_item(sti_pkg::FUNC_INSERT, 0);
    send_item(sti_pkg::FUNC_INSERT, -1);
    send_item(sti_pkg::FUNC_INSERT, 32'sh8000_0000); // equal to the current minimum
    send_item(sti_pkg::FUNC_DELETE, 7);              // absent value
    send_item(sti_pkg::FUNC_DUMP,   32'sh5555_aaaa);
    // Fill the rest of the table, with a duplicate in the middle.
    for (int i = 0; i < 11; i++)
      send_item(sti_pkg::FUNC_INSERT, (i == 6) ? 3 : i * 3 - 15);
    send_item(sti_pkg::FUNC_INSERT, 42);             // insert into a full table
    send_item(sti_pkg::FUNC_DUMP,   0);              // full-length dump
    send_item(sti_pkg::FUNC_DELETE, 32'sh7fff_ffff);
    send_item(sti_pkg::FUNC_DELETE, 32'sh8000_0000); // first of two equal minimums
  endtask

  // Random part: phases that lean toward filling, draining or mixing, so
  // the table swings between empty and full many times.
  task automatic run_random();
    int unsigned counted;
    int unsigned phase_len;
    int unsigned roll;
    mood_t       mood;
    counted = 0;
    while (counted < RandomItems) begin
      mood = mood_t'($urandom_range(2));
      phase_len = $urandom_range(40, 15);
      repeat (phase_len) begin
        if (counted == 30) hold_req = 1'b1;
        steady = (counted >= 90 && counted < 150);
        roll = $urandom_range(99);
        if (roll >= 97) begin
          send_item(FUNC_UNUSED, $urandom);
        end else begin
          if (roll >= 87)
            send_item(sti_pkg::FUNC_DUMP, $urandom);
          else if ((mood == MOOD_FILL  && roll < 65) ||
                   (mood == MOOD_DRAIN && roll < 15) ||
                   (mood == MOOD_MIXED && roll < 45))
            send_item(sti_pkg::FUNC_INSERT, pick_value(1'b0));
          else
            send_item(sti_pkg::FUNC_DELETE, pick_value(1'b1));
          counted++;
        end
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random back-pressure, one long hold-off, and a steady stretch.
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        // Hold off long enough for the block to back up into its input.
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (ReceiverHold) @(negedge clk);
      end
      out_ready = steady || ($urandom_range(99) >= 16);
    end
  end

  // Sample results at the rising edge and check them in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result('{status: out_status, element: out_element, last: out_last});
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = sti_pkg::FUNC_INSERT;
    in_value = '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random();
    @(negedge clk);
    in_valid = 1'b0;

    // Drain: wait for every owed result, then let stray output show up.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d inserts, %0d deletes, %0d dumps and %0d undefined codes;",
             n_insert, n_delete, n_dump, n_ignored);
    $display("%0d results checked, statuses ok %0d, full %0d, not found %0d, empty %0d.",
             tracker.checked,
             tracker.status_seen[sti_pkg::ST_OK], tracker.status_seen[sti_pkg::ST_FULL],
             tracker.status_seen[sti_pkg::ST_NOTFOUND],
             tracker.status_seen[sti_pkg::ST_EMPTY]);
    $display("%0d mismatches.", tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("sorted_table_insert_delete regression: pass");
    else
      $display("sorted_table_insert_delete regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sti_pkg.sv
sv/sti_ram.sv
sv/sti_seq.sv
sv/sorted_table_insert_delete.sv
tb/testbench.sv
